// ===== rtl/multi_key_press_event_machine_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the key press event machine
// Same-cycle and next-cycle checks; both compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef MULTI_KEY_PRESS_EVENT_MACHINE_CORE_MACROS_SVH
`define MULTI_KEY_PRESS_EVENT_MACHINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// ante holds -> cons holds in the same cycle
`define MKPE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mkpe: same-cycle check failed");
// ante holds -> cons holds in the next cycle
`define MKPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mkpe: next-cycle check failed");
`else
`define MKPE_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define MKPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/mkpe_pkg.sv =====
// ----------------------------------------------------------------------------
// mkpe_pkg
// Shared types and codes of the key press event machine.
// ----------------------------------------------------------------------------
package mkpe_pkg;

    localparam int CFG_W     = 32;   // threshold register width
    localparam int EN_W      = 8;    // key enable register width
    localparam int CFG_IDX_W = 2;    // register index width
    localparam int KEYNUM_W  = 4;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ULTRA      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd3;

    typedef enum logic [1:0] {
        OP_UPDATE  = 2'd0,
        OP_PROCESS = 2'd1,
        OP_QUERY   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_HELD     = 2'd2,
        PH_RELEASED = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        EV_PRESS   = 3'd0,
        EV_RELEASE = 3'd1,
        EV_LONG    = 3'd2,
        EV_ULTRA   = 3'd3,
        EV_CLICK   = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_WALK  = 2'd1,
        ST_FLUSH = 2'd2
    } t_state;

    typedef struct packed {
        logic [CFG_W-1:0] long_t;
        logic [CFG_W-1:0] ultra_t;
        logic [CFG_W-1:0] debounce_t;
    } t_thresh;

    // control into one key cell
    typedef struct packed {
        logic load;     // token arrives from the left neighbor
        logic adv;      // chain moves this cycle
        logic en;       // key enabled
        logic upd;      // level update for this key
        logic level;
        logic clr;      // enable rose: clear the key
        logic to_idle;  // enable fell: phase back to idle
    } t_cell_ctl;

    // status out of one key cell
    typedef struct packed {
        logic   tok;
        logic   ev;
        t_event code;
        t_phase phase;
        logic   down;
    } t_cell_sts;

    typedef struct packed {
        logic                kind;
        logic [KEYNUM_W-1:0] key;
        t_event              code;
        t_phase              phase;
        logic                down;
    } t_result;

endpackage

// ===== rtl/mkpe_cell.sv =====
// ----------------------------------------------------------------------------
// mkpe_cell
// One key of the chain: phase, levels, stamps and the tick token.
// ----------------------------------------------------------------------------
module mkpe_cell
    import mkpe_pkg::*;
#(
    parameter int TICK_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  t_thresh               i_thr,
    input  logic [TICK_WIDTH-1:0] i_now,
    output logic [TICK_WIDTH-1:0] o_now,
    output t_cell_sts             o_sts
);

    localparam int CMP_W = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;

    t_phase                r_phase, n_phase;
    logic                  r_lv, r_lb;
    logic [TICK_WIDTH-1:0] r_press, n_press;
    logic [TICK_WIDTH-1:0] r_rel, n_rel;
    logic                  r_tok;
    logic [TICK_WIDTH-1:0] r_now;

    // tick differences wrap at the tick width before widening
    logic [TICK_WIDTH-1:0] w_held_t, w_since_t, w_dur_t;
    logic [CMP_W-1:0] w_held, w_since, w_dur;
    logic [CMP_W-1:0] w_long, w_ultra, w_deb;
    logic             w_step, w_ev;
    t_event           w_code;

    assign w_held_t  = r_now - r_press;
    assign w_since_t = r_now - r_rel;
    assign w_dur_t   = r_rel - r_press;
    assign w_held  = CMP_W'(w_held_t);
    assign w_since = CMP_W'(w_since_t);
    assign w_dur   = CMP_W'(w_dur_t);
    assign w_long  = CMP_W'(i_thr.long_t);
    assign w_ultra = CMP_W'(i_thr.ultra_t);
    assign w_deb   = CMP_W'(i_thr.debounce_t);
    assign w_step  = r_tok & i_ctl.en;

    always_comb begin
        n_phase = r_phase;
        n_press = r_press;
        n_rel   = r_rel;
        w_ev    = 1'b0;
        w_code  = EV_PRESS;
        unique case (r_phase)
            PH_IDLE: begin
                if (r_lv && !r_lb) begin
                    n_press = r_now;
                    n_phase = PH_PRESSED;
                    w_ev    = 1'b1;
                    w_code  = EV_PRESS;
                end
            end
            PH_PRESSED: begin
                if (!r_lv && r_lb) begin
                    n_rel   = r_now;
                    n_phase = PH_RELEASED;
                    w_ev    = 1'b1;
                    w_code  = EV_RELEASE;
                end else if (r_lv && w_held >= w_ultra) begin
                    n_phase = PH_HELD;
                    w_ev    = 1'b1;
                    w_code  = EV_ULTRA;
                end else if (r_lv && w_held >= w_long) begin
                    n_phase = PH_HELD;
                    w_ev    = 1'b1;
                    w_code  = EV_LONG;
                end
            end
            PH_HELD: begin
                if (!r_lv && r_lb) begin
                    n_rel   = r_now;
                    n_phase = PH_RELEASED;
                    w_ev    = 1'b1;
                    w_code  = EV_RELEASE;
                end
            end
            PH_RELEASED: begin
                // click only when the hold was short
                if (!r_lv && w_since >= w_deb) begin
                    n_phase = PH_IDLE;
                    w_ev    = (w_dur < w_long);
                    w_code  = EV_CLICK;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_lv    <= 1'b0;
            r_lb    <= 1'b0;
            r_press <= '0;
            r_rel   <= '0;
        end else if (i_ctl.clr) begin
            r_phase <= PH_IDLE;
            r_lv    <= 1'b0;
            r_lb    <= 1'b0;
            r_press <= '0;
            r_rel   <= '0;
        end else if (i_ctl.to_idle) begin
            r_phase <= PH_IDLE;
        end else if (i_ctl.upd) begin
            r_lb <= r_lv;
            r_lv <= i_ctl.level;
        end else if (w_step && i_ctl.adv) begin
            r_phase <= n_phase;
            r_press <= n_press;
            r_rel   <= n_rel;
        end
    end

    // token and its tick move one cell per advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else if (i_ctl.load) begin
            r_tok <= 1'b1;
        end else if (i_ctl.adv) begin
            r_tok <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_now <= i_now;
        end
    end

    assign o_now       = r_now;
    assign o_sts.tok   = r_tok;
    assign o_sts.ev    = w_step & w_ev;
    assign o_sts.code  = w_code;
    assign o_sts.phase = r_phase;
    assign o_sts.down  = r_lv;

endmodule

// ===== rtl/multi_key_press_event_machine_core.sv =====
// ----------------------------------------------------------------------------
// multi_key_press_event_machine_core
// Button press / release / long / ultra long / click detector for KEYS keys.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser is the operation (update, process, query);
// tdata carries key number, new level and the current tick.
// Output stream (m_axis): event reports and query answers, tlast marks the
// final word caused by one input word, tuser tells report from answer.
// Config port: i_cfg_we / i_cfg_index / i_cfg_data, write only; the user
// must write it only while the block is idle; the block does not enforce it.
// Each key lives in one cell of a chain. A process word launches a token
// with the tick into cell 0; the token moves one cell per cycle while the
// output is free, each enabled cell steps its key as the token passes. A
// process word is accepted, walks the chain, then passes a flush state
// before the next input word is taken. An update takes effect at
// acceptance; a query answer goes via the pending and output registers.
// The newest event is held one step back so tlast can be set on it once
// the walk ends. When the receiver stalls the token stops in place; input
// is taken only between items (s_axis_tready high in idle), while a
// finished word may still sit in the output register.
// Reset: all keys disabled and idle, thresholds 100 / 300 / 2.
// ----------------------------------------------------------------------------
`include "multi_key_press_event_machine_core_macros.svh"

module multi_key_press_event_machine_core
    import mkpe_pkg::*;
#(
    parameter int KEYS       = 8,
    parameter int TICK_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,   // [3:0] key_number, [4] level,
                                                 // [36:5] now_tick, [39:37] zero
    input  logic [1:0]           s_axis_tuser,   // [1:0] operation
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // [3:0] source_key, [6:4] event_code,
                                                 // [8:7] phase, [9] is_down, [15:10] zero
    output logic                 m_axis_tlast,   // last_of_run
    output logic                 m_axis_tuser,   // [0] kind
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // ---- input word fields
    logic [KEYNUM_W-1:0]   w_kn;
    logic                  w_level;
    logic [TICK_WIDTH-1:0] w_now;
    t_op                   w_op;
    logic                  w_accept;

    assign w_kn     = s_axis_tdata[3:0];
    assign w_level  = s_axis_tdata[4];
    assign w_now    = TICK_WIDTH'(s_axis_tdata[36:5]);
    assign w_op     = t_op'(s_axis_tuser);
    assign w_accept = s_axis_tvalid & s_axis_tready;

    // ---- config registers
    logic [EN_W-1:0] r_key_en;
    t_thresh         r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_en           <= '0;
            r_thr.long_t       <= CFG_W'(100);
            r_thr.ultra_t      <= CFG_W'(300);
            r_thr.debounce_t   <= CFG_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KEY_ENABLE: r_key_en         <= i_cfg_data[EN_W-1:0];
                REG_LONG:       r_thr.long_t     <= i_cfg_data;
                REG_ULTRA:      r_thr.ultra_t    <= i_cfg_data;
                REG_DEBOUNCE:   r_thr.debounce_t <= i_cfg_data;
                default:        r_key_en         <= r_key_en;
            endcase
        end
    end

    // ---- control state
    t_state  r_state, n_state;
    t_result r_pend, n_pend;
    logic    r_pend_valid, n_pend_valid;
    t_result r_out;
    logic    r_out_valid, r_out_last;
    logic    w_out_free, w_adv, w_load_out, w_load_last;
    t_result w_load_res;

    // ---- the chain
    t_cell_ctl             w_ctl [KEYS];
    t_cell_sts             w_sts [KEYS];
    logic [TICK_WIDTH-1:0] w_cnow[KEYS];
    logic [KEYS-1:0]       w_tok;
    logic [KEYS-1:0]       w_en;
    logic [KEYS-1:0]       w_sel;
    logic [KEYS-1:0]       w_rise, w_fall;
    logic                  w_launch;

    for (genvar g = 0; g < KEYS; g++) begin : g_key
        // keys past the enable register are never enabled
        if (g < EN_W) begin : g_en
            assign w_en[g]   = r_key_en[g];
            assign w_rise[g] = i_cfg_we && (i_cfg_index == REG_KEY_ENABLE)
                               && i_cfg_data[g] && !r_key_en[g];
            assign w_fall[g] = i_cfg_we && (i_cfg_index == REG_KEY_ENABLE)
                               && !i_cfg_data[g] && r_key_en[g];
        end else begin : g_noen
            assign w_en[g]   = 1'b0;
            assign w_rise[g] = 1'b0;
            assign w_fall[g] = 1'b0;
        end

        assign w_tok[g] = w_sts[g].tok;
        assign w_sel[g] = (32'(w_kn) == g + 1) && w_en[g];

        assign w_ctl[g].adv     = w_adv;
        assign w_ctl[g].en      = w_en[g];
        assign w_ctl[g].upd     = w_accept && (w_op == OP_UPDATE) && w_sel[g];
        assign w_ctl[g].level   = w_level;
        assign w_ctl[g].clr     = w_rise[g];
        assign w_ctl[g].to_idle = w_fall[g];

        if (g == 0) begin : g_head
            assign w_ctl[g].load = w_launch;
            mkpe_cell #(.TICK_WIDTH(TICK_WIDTH)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[g]),
                .i_thr   (r_thr),
                .i_now   (w_now),
                .o_now   (w_cnow[g]),
                .o_sts   (w_sts[g])
            );
        end else begin : g_body
            assign w_ctl[g].load = w_adv && w_tok[g-1];
            mkpe_cell #(.TICK_WIDTH(TICK_WIDTH)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl[g]),
                .i_thr   (r_thr),
                .i_now   (w_cnow[g-1]),
                .o_now   (w_cnow[g]),
                .o_sts   (w_sts[g])
            );
        end
    end

    // ---- event pick (at most one cell holds the token) and query read
    logic                w_ev_hit;
    logic [KEYNUM_W-1:0] w_ev_key;
    t_event              w_ev_code;
    t_phase              w_q_phase;
    logic                w_q_down;

    always_comb begin
        w_ev_hit  = 1'b0;
        w_ev_key  = '0;
        w_ev_code = EV_PRESS;
        w_q_phase = PH_IDLE;
        w_q_down  = 1'b0;
        for (int i = 0; i < KEYS; i++) begin
            w_ev_hit  = w_ev_hit | w_sts[i].ev;
            w_ev_key  = w_ev_key | (w_sts[i].ev ? KEYNUM_W'(i + 1) : '0);
            w_ev_code = t_event'(w_ev_code | (w_sts[i].ev ? w_sts[i].code : EV_PRESS));
            w_q_phase = t_phase'(w_q_phase | (w_sel[i] ? w_sts[i].phase : PH_IDLE));
            w_q_down  = w_q_down | (w_sel[i] & w_sts[i].down);
        end
    end

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_adv         = (r_state == ST_WALK) && w_out_free;
    assign w_launch      = w_accept && (w_op == OP_PROCESS);

    // ---- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    always_comb begin
        n_state      = r_state;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        w_load_out   = 1'b0;
        w_load_last  = 1'b0;
        w_load_res   = r_pend;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        OP_PROCESS: n_state = ST_WALK;
                        OP_QUERY: begin
                            n_pend.kind  = 1'b1;
                            n_pend.key   = w_kn;
                            n_pend.code  = EV_PRESS;
                            n_pend.phase = w_q_phase;
                            n_pend.down  = w_q_down;
                            n_pend_valid = 1'b1;
                            n_state      = ST_FLUSH;
                        end
                        default: n_state = ST_IDLE;  // update, or no-op code
                    endcase
                end
            end
            ST_WALK: begin
                if (w_adv) begin
                    if (w_ev_hit) begin
                        // older event is now known not to be the last
                        w_load_out   = r_pend_valid;
                        n_pend.kind  = 1'b0;
                        n_pend.key   = w_ev_key;
                        n_pend.code  = w_ev_code;
                        n_pend.phase = PH_IDLE;
                        n_pend.down  = 1'b0;
                        n_pend_valid = 1'b1;
                    end
                    if (w_tok[KEYS-1]) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    w_load_out   = 1'b1;
                    w_load_last  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out      <= w_load_res;
            r_out_last <= w_load_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {6'b0, r_out.down, r_out.phase, r_out.code, r_out.key};

    // ---- checks
    `MKPE_ASSERT_SAME(a_tok_single, i_clk, i_rst_n, 1'b1, $onehot0(w_tok))
    `MKPE_ASSERT_SAME(a_idle_empty, i_clk, i_rst_n, r_state == ST_IDLE,
                      (w_tok == '0) && !r_pend_valid)
    `MKPE_ASSERT_NEXT(a_launch, i_clk, i_rst_n, w_launch,
                      (r_state == ST_WALK) && w_tok[0])
    `MKPE_ASSERT_NEXT(a_walk_end, i_clk, i_rst_n, w_adv && w_tok[KEYS-1],
                      r_state == ST_FLUSH)
    `MKPE_ASSERT_NEXT(a_flush_last, i_clk, i_rst_n,
                      (r_state == ST_FLUSH) && r_pend_valid && w_out_free,
                      r_out_valid && r_out_last)

endmodule

// ===== bench/multi_key_press_event_machine_core_tb.sv =====
// ----------------------------------------------------------------------------
// multi_key_press_event_machine_core_tb
// Self-checking bench for the key press event machine. Level updates,
// process ticks and queries go in over the input stream. A scoreboard class
// keeps its own copy of the per-key state and thresholds, predicts every
// event report and query answer, and checks each output word in order.
// ----------------------------------------------------------------------------
module multi_key_press_event_machine_core_tb
    import mkpe_pkg::*;
();

    localparam int NKEYS     = 8;
    localparam int SETTLE_CY = 2 * NKEYS + 4;   // walk + flush + output slack
    localparam int HOLD_CY   = 80;              // long receiver hold-off
    localparam int PHASE_LEN = 25;

    // the fourth operation code has no enum member: the block must drop it
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // one output word as the bench sees it
    typedef struct packed {
        logic                kind;
        logic [KEYNUM_W-1:0] key;
        t_event              code;
        t_phase              phase;
        logic                down;
        logic                last;
    } t_report;

    // ------------------------------------------------------------------------
    // Scoreboard: own model of every key plus the queue of expected words
    // ------------------------------------------------------------------------
    class key_event_board;
        logic [7:0]  en_mask;
        logic [31:0] long_lim;
        logic [31:0] ultra_lim;
        logic [31:0] debounce_lim;
        t_phase      key_phase  [NKEYS];
        logic        lvl_now    [NKEYS];
        logic        lvl_prev   [NKEYS];
        logic [31:0] press_at   [NKEYS];
        logic [31:0] release_at [NKEYS];
        t_report     pending [$];
        int          errors;
        int          words_taken;
        int          answers_seen;
        int          reg_writes;
        int          code_hits [5];

        function new();
            en_mask      = '0;
            long_lim     = 32'd100;
            ultra_lim    = 32'd300;
            debounce_lim = 32'd2;
            errors       = 0;
            words_taken  = 0;
            answers_seen = 0;
            reg_writes   = 0;
            foreach (code_hits[c]) code_hits[c] = 0;
            for (int i = 0; i < NKEYS; i++) clear_key(i);
        endfunction

        function void clear_key(int i);
            key_phase[i]  = PH_IDLE;
            lvl_now[i]    = 1'b0;
            lvl_prev[i]   = 1'b0;
            press_at[i]   = '0;
            release_at[i] = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            reg_writes++;
            case (idx)
                REG_KEY_ENABLE: begin
                    // rising enable clears the key, falling one only idles it
                    for (int i = 0; i < NKEYS; i++) begin
                        if (val[i] && !en_mask[i]) clear_key(i);
                        else if (!val[i] && en_mask[i]) key_phase[i] = PH_IDLE;
                    end
                    en_mask = val[7:0];
                end
                REG_LONG:     long_lim     = val;
                REG_ULTRA:    ultra_lim    = val;
                REG_DEBOUNCE: debounce_lim = val;
                default: ;
            endcase
        endfunction

        // one key at one tick; returns 1 with the event when it fires
        function bit step_key(int i, logic [31:0] now, output t_event ev);
            logic [31:0] held;
            logic [31:0] since_rel;
            logic [31:0] span;
            logic        dn;
            logic        was;
            held      = now - press_at[i];
            since_rel = now - release_at[i];
            span      = release_at[i] - press_at[i];
            dn        = lvl_now[i];
            was       = lvl_prev[i];
            ev        = EV_PRESS;
            step_key  = 1'b0;
            case (key_phase[i])
                PH_IDLE: begin
                    if (dn && !was) begin
                        press_at[i]  = now;
                        key_phase[i] = PH_PRESSED;
                        ev           = EV_PRESS;
                        step_key     = 1'b1;
                    end
                end
                PH_PRESSED: begin
                    if (!dn && was) begin
                        release_at[i] = now;
                        key_phase[i]  = PH_RELEASED;
                        ev            = EV_RELEASE;
                        step_key      = 1'b1;
                    end else if (dn && held >= ultra_lim) begin
                        // ultra long wins over long
                        key_phase[i] = PH_HELD;
                        ev           = EV_ULTRA;
                        step_key     = 1'b1;
                    end else if (dn && held >= long_lim) begin
                        key_phase[i] = PH_HELD;
                        ev           = EV_LONG;
                        step_key     = 1'b1;
                    end
                end
                PH_HELD: begin
                    if (!dn && was) begin
                        release_at[i] = now;
                        key_phase[i]  = PH_RELEASED;
                        ev            = EV_RELEASE;
                        step_key      = 1'b1;
                    end
                end
                default: begin
                    // released: wait out debounce, click only on a short hold
                    if (!dn && since_rel >= debounce_lim) begin
                        key_phase[i] = PH_IDLE;
                        if (span < long_lim) begin
                            ev       = EV_CLICK;
                            step_key = 1'b1;
                        end
                    end
                end
            endcase
        endfunction

        // accepted input word -> state update and expected output words
        function void take_word(logic [1:0] op, logic [3:0] key, logic lvl,
                                logic [31:0] tick);
            bit      ok;
            bit      have;
            int      k;
            t_event  ev;
            t_report rpt;
            words_taken++;
            k    = int'(key) - 1;
            ok   = (key >= 1) && (key <= NKEYS) && en_mask[k];
            have = 1'b0;
            rpt  = '0;
            case (op)
                OP_UPDATE: begin
                    if (ok) begin
                        lvl_prev[k] = lvl_now[k];
                        lvl_now[k]  = lvl;
                    end
                end
                OP_PROCESS: begin
                    // hold each report back one step so the last gets tlast
                    for (int i = 0; i < NKEYS; i++) begin
                        if (en_mask[i] && step_key(i, tick, ev)) begin
                            if (have) pending.push_back(rpt);
                            rpt       = '0;
                            rpt.key   = KEYNUM_W'(i + 1);
                            rpt.code  = ev;
                            rpt.phase = PH_IDLE;
                            have      = 1'b1;
                        end
                    end
                    if (have) begin
                        rpt.last = 1'b1;
                        pending.push_back(rpt);
                    end
                end
                OP_QUERY: begin
                    rpt.kind  = 1'b1;
                    rpt.key   = key;
                    rpt.code  = EV_PRESS;
                    rpt.phase = ok ? key_phase[k] : PH_IDLE;
                    rpt.down  = ok ? lvl_now[k] : 1'b0;
                    rpt.last  = 1'b1;
                    pending.push_back(rpt);
                end
                default: ;
            endcase
        endfunction

        function void field_cmp(string name, logic [3:0] want_v, logic [3:0] got_v);
            if (got_v !== want_v) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want_v, got_v);
                errors++;
            end
        endfunction

        // accepted output word against the oldest expectation
        function void match_report(t_report got);
            t_report want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected output word, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want.kind) answers_seen++;
            else code_hits[want.code]++;
            field_cmp("kind",  4'(want.kind),  4'(got.kind));
            field_cmp("key",   want.key,       got.key);
            field_cmp("event", 4'(want.code),  4'(got.code));
            field_cmp("phase", 4'(want.phase), 4'(got.phase));
            field_cmp("down",  4'(want.down),  4'(got.down));
            field_cmp("last",  4'(want.last),  4'(got.last));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [39:0]          s_axis_tdata = '0;   // [3:0] key, [4] level, [36:5] tick
    logic [1:0]           s_axis_tuser = '0;   // [1:0] operation
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;        // [3:0] key, [6:4] event, [8:7] phase,
                                               // [9] down
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;        // [0] kind
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    multi_key_press_event_machine_core #(
        .KEYS       (NKEYS),
        .TICK_WIDTH (32)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    key_event_board board = new();

    bit          calm = 1'b0;     // no idling on either side while set
    int          hold_asked = 0;  // bumped by stimulus to request a hold-off
    logic [31:0] tick_now = '0;

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    int hold_given = 0;
    int hold_left  = 0;

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_asked != hold_given) begin
            hold_given    <= hold_given + 1;
            hold_left     <= HOLD_CY;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    // output words are checked at the edge that takes them
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.match_report({m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[6:4],
                                m_axis_tdata[8:7], m_axis_tdata[9], m_axis_tlast});
    end

    // ------------------------------------------------------------------------
    // Sender tasks; each is entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [1:0] op, input logic [3:0] key,
                             input logic lvl, input logic [31:0] tick);
        while (!calm && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, tick, lvl, key};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.take_word(op, key, lvl, tick);
        @(negedge i_clk);
    endtask

    // drop valid, wait out every expected word, then let the walk finish
    task automatic settle();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0 && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (SETTLE_CY) @(negedge i_clk);
    endtask

    // all four registers in index order; only called while the block is idle
    task automatic apply_setting(input logic [7:0] en, input logic [31:0] lg,
                                 input logic [31:0] ul, input logic [31:0] db);
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     val;
        for (int r = 0; r < 4; r++) begin
            case (r)
                0:       begin idx = REG_KEY_ENABLE; val = {24'd0, en}; end
                1:       begin idx = REG_LONG;       val = lg;          end
                2:       begin idx = REG_ULTRA;      val = ul;          end
                default: begin idx = REG_DEBOUNCE;   val = db;          end
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            board.write_reg(idx, val);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // mostly well-formed key traffic: toggling levels on keys 1 to NKEYS,
    // ticks that creep forward, some bad key numbers and reserved ops
    task automatic random_word();
        int         roll;
        logic [3:0] k;
        logic       lv;
        roll = $urandom_range(0, 99);
        k    = 4'($urandom_range(1, NKEYS));
        if ($urandom_range(0, 9) == 0) k = 4'($urandom_range(0, 15));
        lv = 1'($urandom_range(0, 1));
        if (roll < 42) begin
            if (k >= 1 && k <= NKEYS && $urandom_range(0, 99) < 80)
                lv = ~board.lvl_now[k - 1];
            send_word(OP_UPDATE, k, lv, $urandom());
        end else if (roll < 82) begin
            if ($urandom_range(0, 9) == 0) tick_now += $urandom_range(0, 90);
            else tick_now += $urandom_range(0, 8);
            send_word(OP_PROCESS, 4'($urandom_range(0, 15)), lv, tick_now);
        end else if (roll < 97) begin
            send_word(OP_QUERY, k, lv, $urandom());
        end else begin
            send_word(OP_RESERVED, k, lv, $urandom());
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [7:0]  en;
        logic [31:0] lg;
        logic [31:0] ul;
        logic [31:0] db;
        int          left;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset thresholds, nothing enabled: updates and ticks are ignored, the query answers idle
        send_word(OP_QUERY, 4'd1, 1'b0, 32'd0);
        send_word(OP_UPDATE, 4'd1, 1'b1, 32'hFFFF_FFFF);
        send_word(OP_PROCESS, 4'd0, 1'b0, 32'd5);
        settle();

        apply_setting(8'hFF, 32'd10, 32'd30, 32'd2);
        // bad key numbers, reserved op
        send_word(OP_QUERY, 4'd0, 1'b0, 32'd0);
        send_word(OP_QUERY, 4'd15, 1'b1, 32'hFFFF_FFFF);
        send_word(OP_QUERY, 4'd9, 1'b0, 32'd0);
        send_word(OP_RESERVED, 4'd1, 1'b1, 32'd7);
        send_word(OP_UPDATE, 4'd0, 1'b1, 32'd0);
        send_word(OP_UPDATE, 4'd12, 1'b1, 32'd0);
        // two presses in one walk, then long on both plus a press
        send_word(OP_UPDATE, 4'd1, 1'b1, $urandom());
        send_word(OP_UPDATE, 4'd8, 1'b1, $urandom());
        send_word(OP_PROCESS, 4'd0, 1'b0, 32'd100);
        send_word(OP_UPDATE, 4'd3, 1'b1, $urandom());
        send_word(OP_PROCESS, 4'd0, 1'b0, 32'd110);
        // ultra long on key 3, then release of a long hold: no click
        send_word(OP_PROCESS, 4'd0, 1'b0, 32'd140);
        send_word(OP_UPDATE, 4'd1, 1'b0, $urandom());
        send_word(OP_PROCESS, 4'd0, 1'b0, 32'd141);
        send_word(OP_PROCESS, 4'd0, 1'b0, 32'd143);
        // short press across the tick wrap, click after debounce
        send_word(OP_UPDATE, 4'd5, 1'b1, $urandom());
        send_word(OP_PROCESS, 4'd0, 1'b0, 32'hFFFF_FFFF);
        send_word(OP_UPDATE, 4'd5, 1'b0, $urandom());
        send_word(OP_PROCESS, 4'd0, 1'b0, 32'd0);
        send_word(OP_PROCESS, 4'd0, 1'b0, 32'd1);
        send_word(OP_PROCESS, 4'd0, 1'b0, 32'd2);
        send_word(OP_QUERY, 4'd3, 1'b0, 32'd0);
        send_word(OP_QUERY, 4'd5, 1'b0, 32'd0);
        settle();

        // upper keys fall (phase idles, levels kept), then rise (cleared)
        apply_setting(8'h0F, 32'd10, 32'd30, 32'd2);
        send_word(OP_QUERY, 4'd8, 1'b0, 32'd0);
        settle();
        apply_setting(8'hFF, 32'd10, 32'd30, 32'd2);
        send_word(OP_QUERY, 4'd8, 1'b0, 32'd0);
        settle();

        for (int p = 0; p < 6; p++) begin
            en       = 8'($urandom_range(1, 255));
            lg       = $urandom_range(2, 25);
            ul       = lg + $urandom_range(0, 40);
            db       = $urandom_range(0, 6);
            tick_now = $urandom();
            case (p)
                0: begin
                    // every press turns long at once; ticks cross the wrap
                    en = 8'hFF; lg = '0; ul = '1; db = '0;
                    tick_now = 32'hFFFF_FFC0;
                end
                1: begin ul = '0; lg = 32'd5; db = '1; end
                2: begin
                    // no idling anywhere; every release ends in a click
                    calm = 1'b1;
                    en = 8'hFF; lg = '1; ul = '1;
                end
                3: en = 8'hFF;
                default: ;
            endcase
            apply_setting(en, lg, ul, db);
            left = PHASE_LEN;
            if (p == 3) begin
                // press every key, then stall the receiver while queries and
                // process ticks keep coming, so the input side backs up
                for (int k = 1; k <= NKEYS; k++)
                    send_word(OP_UPDATE, 4'(k), 1'b1, $urandom());
                hold_asked++;
                for (int n = 0; n < 10; n++) begin
                    tick_now += $urandom_range(1, 12);
                    send_word(OP_PROCESS, 4'd0, 1'b0, tick_now);
                    send_word(OP_QUERY, 4'($urandom_range(1, NKEYS)), 1'b0, $urandom());
                end
                left = 5;
            end
            while (left > 0) begin
                random_word();
                left--;
                // sender waits for a fully drained output once
                if (p == 4 && left == PHASE_LEN / 2) settle();
            end
            settle();
            calm = 1'b0;
        end

        settle();
        if (board.pending.size() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, board.pending.size());
            board.errors += board.pending.size();
        end
        $display("Run: %0d input words, %0d register writes, %0d query answers",
                 board.words_taken, board.reg_writes, board.answers_seen);
        $display("Events: press %0d, release %0d, long %0d, ultra %0d, click %0d",
                 board.code_hits[EV_PRESS], board.code_hits[EV_RELEASE],
                 board.code_hits[EV_LONG], board.code_hits[EV_ULTRA],
                 board.code_hits[EV_CLICK]);
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #1200000;
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
